// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/b64d_pkg.sv =====
package b64d_pkg;

  localparam logic [6:0] PAD_VALUE = 7'd127;

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;

  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_UPPER_Z = 7'h5a;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_LOWER_Z = 7'h7a;
  localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
  localparam logic [6:0] CHAR_DIGIT_9 = 7'h39;
  localparam logic [6:0] CHAR_PLUS    = 7'h2b;
  localparam logic [6:0] CHAR_SLASH   = 7'h2f;
  localparam logic [6:0] CHAR_EQUALS  = 7'h3d;

  localparam int MAX_RESULTS = 4;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       invalid;
  } result_t;

  // results caused by one accepted item, packed from slot 0 up
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [2:0]                count;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] val;
  } sym_map_t;

  function automatic sym_map_t map_symbol(input logic [6:0] c);
    sym_map_t m;
    m.ok  = 1'b1;
    m.val = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      m.val = 7'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      m.val = 7'(c - CHAR_LOWER_A + 7'd26);
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      m.val = 7'(c - CHAR_DIGIT_0 + 7'd52);
    end else if (c == CHAR_PLUS) begin
      m.val = 7'd62;
    end else if (c == CHAR_SLASH) begin
      m.val = 7'd63;
    end else if (c == CHAR_EQUALS) begin
      m.val = PAD_VALUE;
    end else begin
      m.ok = 1'b0;
    end
    return m;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
  endfunction

endpackage

// ===== hdl/b64d_decode.sv =====
`include "assert_macros.svh"

module b64d_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              char_present,
  input  logic [7:0]        symbol_char,
  input  logic              end_of_string,
  output b64d_pkg::bundle_t bundle
);
  import b64d_pkg::*;

  logic [2:0][6:0] sym;
  logic [2:0][6:0] sym_next;
  logic [1:0]      count;
  logic [1:0]      count_next;
  logic            final_seen;
  logic            final_next;
  logic            err;
  logic            err_next;

  sym_map_t   mapped;
  logic       group_done;
  logic [6:0] s3;
  logic [2:0] n;
  logic [7:0] byte0;
  logic [7:0] byte1;
  logic [7:0] byte2;

  assign mapped = map_symbol(symbol_char[6:0]);

  // byte forms keep the padding value's bits as a full shift-and-or cut to eight bits would
  assign byte0 = {sym[0][5:0], 2'b00} | {5'b0, sym[1][6:4]};
  assign byte1 = {sym[1][3:0], 4'b0000} | {3'b000, sym[2][6:2]};
  assign byte2 = {sym[2][1:0], 6'b000000} | {1'b0, s3};

  always_comb begin
    sym_next   = sym;
    count_next = count;
    final_next = final_seen;
    err_next   = err;
    group_done = 1'b0;
    s3         = '0;
    n          = '0;
    bundle     = '0;

    if (accept && char_present) begin
      if (symbol_char[7]) begin
        err_next = 1'b1;
      end else if (!mapped.ok) begin
        if (!is_space(symbol_char)) begin
          err_next = 1'b1;
        end
      end else begin
        if (final_seen) begin
          err_next = 1'b1;
        end
        if (count != 2'd3) begin
          sym_next[count] = mapped.val;
          count_next      = 2'(count + 2'd1);
        end else begin
          group_done = 1'b1;
          s3         = mapped.val;
          count_next = '0;
          if (sym[0] == PAD_VALUE || sym[1] == PAD_VALUE) begin
            err_next = 1'b1;
          end
          if (sym[2] == PAD_VALUE || mapped.val == PAD_VALUE) begin
            final_next = 1'b1;
          end
        end
      end
    end

    if (group_done) begin
      bundle.res[n[1:0]] = '{kind: KIND_DATA, data: byte0, invalid: 1'b0};
      n = 3'(n + 3'd1);
      if (sym[2] != PAD_VALUE) begin
        bundle.res[n[1:0]] = '{kind: KIND_DATA, data: byte1, invalid: 1'b0};
        n = 3'(n + 3'd1);
      end
      if (s3 != PAD_VALUE) begin
        bundle.res[n[1:0]] = '{kind: KIND_DATA, data: byte2, invalid: 1'b0};
        n = 3'(n + 3'd1);
      end
    end

    if (accept && end_of_string) begin
      bundle.res[n[1:0]] = '{kind: KIND_STATUS, data: 8'h00,
                             invalid: err_next || (count_next != 2'd0)};
      n          = 3'(n + 3'd1);
      sym_next   = '0;
      count_next = '0;
      final_next = 1'b0;
      err_next   = 1'b0;
    end

    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym        <= '0;
      count      <= '0;
      final_seen <= 1'b0;
      err        <= 1'b0;
    end else begin
      sym        <= sym_next;
      count      <= count_next;
      final_seen <= final_next;
      err        <= err_next;
    end
  end

  `ASSERT_NEXT(a_end_clears, clk, rst, accept && end_of_string,
               count == 2'd0 && !final_seen && !err)
  `ASSERT_IMPLIES(a_idle_no_results, clk, rst, !accept, bundle.count == 3'd0)
  `ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1, bundle.count <= 3'd4)

endmodule

// ===== hdl/base64_stream_decoder_top.sv =====
// channel  | dir | tdata                          | tuser        | tlast
// ---------+-----+--------------------------------+--------------+--------------
// s_       | in  | symbol_char                    | char_present | end_of_string
// m_       | out | data_byte, string_invalid, pad | result_kind  | last_of_run
//
// one item is taken per cycle while results keep flowing; each item decodes
// in the cycle it is accepted into a four-slot result buffer
// the result buffer drains one result per cycle while m_tready is high, so an
// item with more than one result holds s_tready low until the last is taken
// rst is synchronous and clears the decode state and the result buffer
// a stall on m_tready holds the buffer and, while any result is waiting,
// the input side as well
`include "assert_macros.svh"

module base64_stream_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol_char
  input  logic        s_tuser,   // [0] char_present
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] data_byte, [8] string_invalid, [15:9] zero
  output logic        m_tuser,   // [0] result_kind
  output logic        m_tlast
);
  import b64d_pkg::*;

  logic    accept;
  bundle_t bundle;

  result_t [MAX_RESULTS-1:0] ent;
  logic [2:0]                cnt;
  logic [1:0]                rd;
  logic                      last;
  logic                      pop;
  result_t                   cur;

  assign last     = rd == 2'(cnt - 3'd1);
  assign m_tvalid = cnt != 3'd0;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (cnt == 3'd0) || (m_tready && last);
  assign accept   = s_tvalid && s_tready;

  b64d_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .char_present  (s_tuser),
    .symbol_char   (s_tdata),
    .end_of_string (s_tlast),
    .bundle        (bundle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rd  <= '0;
    end else if (accept && bundle.count != 3'd0) begin
      cnt <= bundle.count;
      rd  <= '0;
    end else if (pop) begin
      if (last) begin
        cnt <= '0;
        rd  <= '0;
      end else begin
        rd <= 2'(rd + 2'd1);
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && bundle.count != 3'd0) begin
      ent <= bundle.res;
    end
  end

  assign cur     = ent[rd];
  assign m_tdata = {7'b0, cur.invalid, cur.data};
  assign m_tuser = cur.kind;
  assign m_tlast = last;

  `ASSERT_IMPLIES(a_status_is_last, clk, rst, m_tvalid && m_tuser == KIND_STATUS,
                  m_tlast && m_tdata[7:0] == 8'h00)
  `ASSERT_IMPLIES(a_data_valid_flag, clk, rst, m_tvalid && m_tuser == KIND_DATA,
                  !m_tdata[8])
  `ASSERT_NEXT(a_drain_empty, clk, rst, pop && last && !(accept && bundle.count != 3'd0),
               !m_tvalid)

endmodule

// ===== sim/tb_base64_stream_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_base64_stream_decoder_top;
  import b64d_pkg::*;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic       invalid;
    logic       last;
  } decoded_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // decoder state mirrored by the testbench
  logic [6:0] grp_sym [3];
  logic [1:0] grp_cnt;
  logic       pad_group_done;
  logic       string_bad;

  decoded_t decoded_q[$];
  decoded_t head_res;
  int       errors;
  int       items_done;
  int       hold_left;
  bit       idle_on;
  string    alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  base64_stream_decoder_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("FAIL base64_stream_decoder_top");
    $finish;
  end

  function automatic bit sym_value(input logic [6:0] c, output logic [6:0] v);
    v = '0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      v = c - CHAR_UPPER_A;
      return 1'b1;
    end
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      v = c - CHAR_LOWER_A + 7'd26;
      return 1'b1;
    end
    if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      v = c - CHAR_DIGIT_0 + 7'd52;
      return 1'b1;
    end
    case (c)
      CHAR_PLUS:   v = 7'd62;
      CHAR_SLASH:  v = 7'd63;
      CHAR_EQUALS: v = PAD_VALUE;
      default:     return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic decoded_t data_result(input int value);
    decoded_t r;
    r.kind    = KIND_DATA;
    r.data    = 8'(value);
    r.invalid = 1'b0;
    r.last    = 1'b0;
    return r;
  endfunction

  function automatic void clear_state();
    foreach (grp_sym[i]) grp_sym[i] = '0;
    grp_cnt        = '0;
    pad_group_done = 1'b0;
    string_bad     = 1'b0;
  endfunction

  // work out the results one accepted item causes and queue them
  function automatic void decode_item(input bit present, input logic [7:0] ch, input bit eos);
    decoded_t   run[$];
    decoded_t   r;
    logic [6:0] v;
    int         s0, s1, s2, s3;
    if (present) begin
      if (ch[7]) begin
        string_bad = 1'b1;
      end else if (!sym_value(ch[6:0], v)) begin
        if (!(ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_LF || ch == CHAR_CR))
          string_bad = 1'b1;
      end else begin
        if (pad_group_done) string_bad = 1'b1;
        if (grp_cnt != 2'd3) begin
          grp_sym[grp_cnt] = v;
          grp_cnt = grp_cnt + 2'd1;
        end else begin
          s0 = grp_sym[0];
          s1 = grp_sym[1];
          s2 = grp_sym[2];
          s3 = v;
          if (s0 == PAD_VALUE || s1 == PAD_VALUE) string_bad = 1'b1;
          if (s2 == PAD_VALUE || s3 == PAD_VALUE) pad_group_done = 1'b1;
          run.push_back(data_result((s0 << 2) | (s1 >> 4)));
          if (s2 != PAD_VALUE) run.push_back(data_result(((s1 & 'hf) << 4) | (s2 >> 2)));
          if (s3 != PAD_VALUE) run.push_back(data_result(((s2 & 'h3) << 6) | s3));
          grp_cnt = '0;
        end
      end
    end
    if (eos) begin
      r.kind    = KIND_STATUS;
      r.data    = '0;
      r.invalid = string_bad || grp_cnt != 2'd0;
      r.last    = 1'b0;
      run.push_back(r);
      clear_state();
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) decoded_q.push_back(run[i]);
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // result side: check each result taken, then choose m_tready for the next cycle
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0b data %02h inv %0b last %0b",
                 $time, m_tuser, m_tdata[7:0], m_tdata[8], m_tlast);
        errors++;
      end else begin
        head_res = decoded_q.pop_front();
        check_field("result_kind", head_res.kind, m_tuser);
        check_field("data_byte", head_res.data, m_tdata[7:0]);
        check_field("string_invalid", head_res.invalid, m_tdata[8]);
        check_field("last_of_run", head_res.last, m_tlast);
      end
    end
    if (rst || hold_left != 0) begin
      m_tready <= 1'b0;
    end else if (idle_on) begin
      m_tready <= ($urandom_range(99) >= 33);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // long output hold-off, counted down here
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  task automatic send_char(input bit present, input logic [7:0] ch, input bit eos);
    int gap;
    gap = 0;
    // each cycle idles with about one chance in three
    while (idle_on && $urandom_range(99) < 33) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= present;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_item(present, ch, eos);
    if (present || eos) items_done++;
  endtask

  task automatic send_text(input string txt, input bit eos_on_last);
    for (int i = 0; i < txt.len(); i++) begin
      send_char(1'b1, txt[i], eos_on_last && i == txt.len() - 1);
    end
  endtask

  // sender pauses until every expected result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  // one encoded string: mostly well formed groups, sometimes broken or pure noise
  task automatic send_random_string(input bit well_formed_only);
    logic [7:0] chars[$];
    logic [7:0] ws;
    int         ngrp, tail, pos, len;
    bit         eos_alone;
    if (well_formed_only || $urandom_range(99) < 70) begin
      ngrp = $urandom_range(0, 2);
      repeat (ngrp) repeat (4) chars.push_back(alphabet[$urandom_range(63)]);
      tail = $urandom_range(3);
      if (tail != 3) begin
        chars.push_back(alphabet[$urandom_range(63)]);
        chars.push_back(alphabet[$urandom_range(63)]);
        chars.push_back(tail == 2 ? {1'b0, CHAR_EQUALS} : alphabet[$urandom_range(63)]);
        chars.push_back(tail == 0 ? alphabet[$urandom_range(63)] : {1'b0, CHAR_EQUALS});
      end
      if (!well_formed_only && $urandom_range(99) < 25) begin
        pos = $urandom_range(chars.size());
        case ($urandom_range(2))
          0: chars.insert(pos, 8'($urandom_range(255)));
          1: chars.insert(pos, {1'b0, CHAR_EQUALS});
          default: if (pos < chars.size()) chars.delete(pos);
        endcase
      end
    end else begin
      len = $urandom_range(1, 8);
      repeat (len) begin
        chars.push_back($urandom_range(1) ? alphabet[$urandom_range(63)]
                                          : 8'($urandom_range(255)));
      end
    end
    eos_alone = chars.size() == 0 || $urandom_range(1);
    foreach (chars[i]) begin
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(3))
          0: ws = CHAR_SPACE;
          1: ws = CHAR_TAB;
          2: ws = CHAR_LF;
          default: ws = CHAR_CR;
        endcase
        send_char(1'b1, ws, 1'b0);
      end
      // item with no character and no end marker, ignored by the block
      if ($urandom_range(99) < 5) send_char(1'b0, 8'($urandom_range(255)), 1'b0);
      send_char(1'b1, chars[i], !eos_alone && i == chars.size() - 1);
    end
    if (eos_alone) send_char(1'b0, 8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_directed();
    // alphabet extremes, pad in fourth position, then a bare end marker
    send_text("AZaz+/9=", 1'b0);
    send_char(1'b0, 8'ha5, 1'b1);
    // all four blanks, pad in third and fourth position, end on a blank
    send_char(1'b1, "0", 1'b0);
    send_char(1'b1, CHAR_TAB, 1'b0);
    send_char(1'b1, "0", 1'b0);
    send_char(1'b1, "=", 1'b0);
    send_char(1'b1, CHAR_LF, 1'b0);
    send_char(1'b1, "=", 1'b0);
    send_char(1'b1, CHAR_CR, 1'b0);
    send_char(1'b1, CHAR_SPACE, 1'b1);
    // high bit and unmapped characters
    send_char(1'b1, 8'h80, 1'b0);
    send_char(1'b1, 8'hff, 1'b0);
    send_char(1'b1, "*", 1'b0);
    send_char(1'b1, 8'h00, 1'b0);
    send_char(1'b0, 8'h00, 1'b0);
    // leading pad, pad in third with a real fourth symbol, symbol after the
    // final group and an unfinished group at the end
    send_text("=A=B", 1'b0);
    send_char(1'b1, "C", 1'b1);
    wait_drained();
  endtask

  task automatic test_output_stall();
    hold_left <= 150;
    repeat (4) send_random_string(1'b1);
    wait_drained();
  endtask

  task automatic test_steady_stream();
    idle_on <= 1'b0;
    repeat (6) send_random_string(1'b0);
    wait_drained();
    idle_on <= 1'b1;
  endtask

  task automatic test_random_strings(input int item_goal);
    int start;
    start = items_done;
    while (items_done - start < item_goal) send_random_string(1'b0);
    wait_drained();
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    s_tlast    = 1'b0;
    m_tready   = 1'b0;
    errors     = 0;
    items_done = 0;
    hold_left  = 0;
    idle_on    = 1'b1;
    clear_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_output_stall();
    test_random_strings(30);
    test_steady_stream();
    test_random_strings(30);

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS base64_stream_decoder_top");
    end else begin
      $display("FAIL base64_stream_decoder_top");
    end
    $finish;
  end

endmodule
